// File: design/arcd_pkg.sv
// ----------------------------------------------------------------------------
// arcd_pkg
// Shared types, constants and helpers for the audio rate change detector.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package arcd_pkg;

    localparam int RATE_NUM    = 7;
    localparam int RATE_CODE_W = 3;
    localparam int COUNT_W     = 18;
    localparam int MAP_W       = 8;
    localparam int HZ_W        = 18;
    localparam int NOM_W       = 15;
    localparam int THR_W       = 8;
    localparam int SHIFT_W     = 4;
    localparam int CFG_IDX_W   = 1;
    localparam int CFG_DATA_W  = 8;

    localparam int QUEUE_DEPTH_DEFAULT = 2;

    // register indexes on the configuration port
    localparam logic [CFG_IDX_W-1:0] CFG_SETTLE_THRESHOLD = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_TOLERANCE_SHIFT  = 1'b1;

    localparam logic [THR_W-1:0]   SETTLE_THRESHOLD_RST = 8'd30;
    localparam logic [SHIFT_W-1:0] TOLERANCE_SHIFT_RST  = 4'd7;

    // rate codes: none, then one per nominal rate in table order
    localparam logic [RATE_CODE_W-1:0] RATE_NONE = 3'd0;

    // nominal edge counts over the measuring window, entry 0 is 32 kHz
    localparam logic [RATE_NUM-1:0][NOM_W-1:0] NOMINAL_COUNT = {
        15'd25166, 15'd23121, 15'd12583, 15'd11561, 15'd6291, 15'd5780, 15'd4194
    };

    typedef struct packed {
        logic [COUNT_W-1:0] rate_count;
        logic [MAP_W-1:0]   channel_map;
    } t_in_item;

    typedef struct packed {
        logic [HZ_W-1:0]  current_rate_hz;
        logic             event_fire;
        logic [HZ_W-1:0]  reported_rate_hz;
        logic [MAP_W-1:0] reported_channel_map;
    } t_out_item;

    // classified item passed from front to back
    typedef struct packed {
        logic [RATE_CODE_W-1:0] rate_code;
        logic [MAP_W-1:0]       channel_map;
    } t_cls_item;

    typedef struct packed {
        logic [THR_W-1:0]   settle_threshold;
        logic [SHIFT_W-1:0] tolerance_shift;
    } t_cfg;

    function automatic logic [HZ_W-1:0] rate_hz(input logic [RATE_CODE_W-1:0] code);
        logic [HZ_W-1:0] hz;
        case (code)
            3'd1:    hz = 18'd32000;
            3'd2:    hz = 18'd44100;
            3'd3:    hz = 18'd48000;
            3'd4:    hz = 18'd88200;
            3'd5:    hz = 18'd96000;
            3'd6:    hz = 18'd176400;
            3'd7:    hz = 18'd192000;
            default: hz = '0;
        endcase
        return hz;
    endfunction

endpackage

`default_nettype wire

// File: design/arcd_front.sv
// ----------------------------------------------------------------------------
// arcd_front
// Accepts count beats, classifies the count to a rate code and registers it.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module arcd_front (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire logic [arcd_pkg::SHIFT_W-1:0] i_tolerance_shift,
    input  wire logic                     i_valid,
    output logic                          o_stall,
    input  wire arcd_pkg::t_in_item       i_item,
    output logic                          o_valid,
    input  wire logic                     i_stall,
    output arcd_pkg::t_cls_item           o_item
);

    logic                 r_valid;
    arcd_pkg::t_cls_item  r_item;
    arcd_pkg::t_cls_item  n_item;

    // seven independent window compares, the last hit wins
    always_comb begin
        logic [arcd_pkg::COUNT_W-1:0] nom;
        logic [arcd_pkg::COUNT_W-1:0] diff;
        logic [arcd_pkg::COUNT_W-1:0] window;
        n_item.rate_code   = arcd_pkg::RATE_NONE;
        n_item.channel_map = i_item.channel_map;
        for (int k = 0; k < arcd_pkg::RATE_NUM; k++) begin
            nom    = arcd_pkg::COUNT_W'(arcd_pkg::NOMINAL_COUNT[k]);
            diff   = (i_item.rate_count >= nom) ? (i_item.rate_count - nom)
                                                : (nom - i_item.rate_count);
            window = nom >> i_tolerance_shift;
            if (diff < window) begin
                n_item.rate_code = arcd_pkg::RATE_CODE_W'(k + 1);
            end
        end
    end

    assign o_stall = r_valid && i_stall;
    assign o_valid = r_valid;
    assign o_item  = r_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_valid && !o_stall) begin
            r_valid <= 1'b1;
        end else if (!i_stall) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && !o_stall) begin
            r_item <= n_item;
        end
    end

endmodule

`default_nettype wire

// File: design/arcd_queue.sv
// ----------------------------------------------------------------------------
// arcd_queue
// Short first-in first-out buffer of classified beats between front and back.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module arcd_queue #(
    parameter int DEPTH = arcd_pkg::QUEUE_DEPTH_DEFAULT
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_valid,
    output logic                     o_stall,
    input  wire arcd_pkg::t_cls_item i_item,
    output logic                     o_valid,
    input  wire logic                i_stall,
    output arcd_pkg::t_cls_item      o_item
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    arcd_pkg::t_cls_item r_mem [DEPTH];
    logic [PTR_W-1:0]    r_wr_ptr;
    logic [PTR_W-1:0]    r_rd_ptr;
    logic [CNT_W-1:0]    r_count;
    logic                push;
    logic                pop;

    assign o_stall = (r_count == CNT_FULL);
    assign o_valid = (r_count != '0);
    assign o_item  = r_mem[r_rd_ptr];
    assign push    = i_valid && !o_stall;
    assign pop     = o_valid && !i_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_LAST) ? '0 : r_wr_ptr + 1'b1;
            end
            if (pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_LAST) ? '0 : r_rd_ptr + 1'b1;
            end
            if (push && !pop) begin
                r_count <= r_count + 1'b1;
            end else if (pop && !push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wr_ptr] <= i_item;
        end
    end

endmodule

`default_nettype wire

// File: design/arcd_back.sv
// ----------------------------------------------------------------------------
// arcd_back
// Change tracking, settle counter and reported rate, with the result register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module arcd_back (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic [arcd_pkg::THR_W-1:0]   i_settle_threshold,
    input  wire logic                         i_valid,
    output logic                              o_stall,
    input  wire arcd_pkg::t_cls_item          i_item,
    output logic                              o_valid,
    input  wire logic                         i_stall,
    output arcd_pkg::t_out_item               o_item
);

    logic [arcd_pkg::RATE_CODE_W-1:0] r_prev_code;
    logic [arcd_pkg::MAP_W-1:0]       r_prev_map;
    logic [arcd_pkg::THR_W-1:0]       r_settle;
    logic [arcd_pkg::RATE_CODE_W-1:0] r_latch_code;
    logic [arcd_pkg::MAP_W-1:0]       r_latch_map;
    logic                             r_valid;
    arcd_pkg::t_out_item              r_item;

    logic [arcd_pkg::THR_W-1:0]       n_settle;
    logic [arcd_pkg::RATE_CODE_W-1:0] n_latch_code;
    logic [arcd_pkg::MAP_W-1:0]       n_latch_map;
    logic                             n_fire;
    logic [arcd_pkg::THR_W-1:0]       cnt;
    logic                             take;

    assign o_stall = r_valid && i_stall;
    assign take    = i_valid && !o_stall;
    assign o_valid = r_valid;
    assign o_item  = r_item;

    always_comb begin
        // a change restarts the settle count at one
        cnt = ((i_item.rate_code != r_prev_code) || (i_item.channel_map != r_prev_map))
            ? arcd_pkg::THR_W'(1) : r_settle;
        n_settle     = cnt;
        n_latch_code = r_latch_code;
        n_latch_map  = r_latch_map;
        n_fire       = 1'b0;
        if (cnt >= i_settle_threshold) begin
            n_settle     = '0;
            n_latch_code = i_item.rate_code;
            n_latch_map  = i_item.channel_map;
            n_fire       = 1'b1;
        end else if (cnt != '0) begin
            n_settle = cnt + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev_code  <= arcd_pkg::RATE_NONE;
            r_prev_map   <= '0;
            r_settle     <= '0;
            r_latch_code <= arcd_pkg::RATE_NONE;
            r_latch_map  <= '0;
            r_valid      <= 1'b0;
        end else begin
            if (take) begin
                r_prev_code  <= i_item.rate_code;
                r_prev_map   <= i_item.channel_map;
                r_settle     <= n_settle;
                r_latch_code <= n_latch_code;
                r_latch_map  <= n_latch_map;
                r_valid      <= 1'b1;
            end else if (!i_stall) begin
                r_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_item.current_rate_hz      <= arcd_pkg::rate_hz(i_item.rate_code);
            r_item.event_fire           <= n_fire;
            r_item.reported_rate_hz     <= arcd_pkg::rate_hz(n_latch_code);
            r_item.reported_channel_map <= n_latch_map;
        end
    end

endmodule

`default_nettype wire

// File: design/audio_rate_change_detector.sv
// ----------------------------------------------------------------------------
// audio_rate_change_detector
// Classifies polled sample-edge counts to a nominal audio rate and reports
// settled changes of rate or channel map.
// ----------------------------------------------------------------------------
// One result beat leaves for every input beat, and a new input beat is taken
// every clock cycle while o_stall is low. A beat passes the classifier
// register, the queue and the result register, in that order. With
// QUEUE_DEPTH entries the block holds up to QUEUE_DEPTH + 2 beats before
// o_stall rises while the output is stalled.
// Write the configuration registers only while no beat is in flight.
`timescale 1ns / 1ps
`default_nettype none

module audio_rate_change_detector #(
    parameter int QUEUE_DEPTH = arcd_pkg::QUEUE_DEPTH_DEFAULT
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_cfg_we,
    input  wire logic [arcd_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  wire logic [arcd_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  wire logic                           i_valid,
    output logic                                o_stall,
    input  wire arcd_pkg::t_in_item             i_item,
    output logic                                o_valid,
    input  wire logic                           i_stall,
    output arcd_pkg::t_out_item                 o_item
);

    arcd_pkg::t_cfg      r_cfg;
    logic                front_valid;
    logic                front_stall;
    arcd_pkg::t_cls_item front_item;
    logic                queue_valid;
    logic                queue_stall;
    arcd_pkg::t_cls_item queue_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.settle_threshold <= arcd_pkg::SETTLE_THRESHOLD_RST;
            r_cfg.tolerance_shift  <= arcd_pkg::TOLERANCE_SHIFT_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                arcd_pkg::CFG_SETTLE_THRESHOLD: begin
                    r_cfg.settle_threshold <= i_cfg_data[arcd_pkg::THR_W-1:0];
                end
                arcd_pkg::CFG_TOLERANCE_SHIFT: begin
                    r_cfg.tolerance_shift <= i_cfg_data[arcd_pkg::SHIFT_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    arcd_front u_front (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_tolerance_shift (r_cfg.tolerance_shift),
        .i_valid           (i_valid),
        .o_stall           (o_stall),
        .i_item            (i_item),
        .o_valid           (front_valid),
        .i_stall           (front_stall),
        .o_item            (front_item)
    );

    arcd_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (front_valid),
        .o_stall (front_stall),
        .i_item  (front_item),
        .o_valid (queue_valid),
        .i_stall (queue_stall),
        .o_item  (queue_item)
    );

    arcd_back u_back (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_settle_threshold (r_cfg.settle_threshold),
        .i_valid            (queue_valid),
        .o_stall            (queue_stall),
        .i_item             (queue_item),
        .o_valid            (o_valid),
        .i_stall            (i_stall),
        .o_item             (o_item)
    );

endmodule

`default_nettype wire

// File: tb/sv/audio_rate_change_detector_test.sv
// ----------------------------------------------------------------------------
// audio_rate_change_detector_test
// Drives poll ticks of edge count and channel map through the detector under
// random input gaps and output stalls. Each result beat is checked against
// typed values or a behavioural rate classifier and settle counter tracking
// the register settings. A short directed table runs first, then long runs of
// steady and jittered counts over several threshold and tolerance settings.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module audio_rate_change_detector_test;
    import arcd_pkg::*;

    localparam logic [HZ_W-1:0] NOMINAL_HZ [RATE_NUM] = '{
        18'd32000, 18'd44100, 18'd48000, 18'd88200, 18'd96000, 18'd176400, 18'd192000
    };

    typedef enum logic {ROW_TICK, ROW_REG} t_row_kind;

    typedef struct {
        t_row_kind              kind;
        logic [CFG_IDX_W-1:0]   reg_idx;
        logic [CFG_DATA_W-1:0]  reg_data;
        t_in_item               beat;
        bit                     typed;
        t_out_item              want;
    } t_row;

    logic                  i_clk      = 1'b0;
    logic                  i_rst_n    = 1'b0;
    logic                  i_cfg_we   = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_idx  = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;
    logic                  i_valid    = 1'b0;
    logic                  o_stall;
    t_in_item              i_item     = '0;
    logic                  o_valid;
    logic                  i_stall    = 1'b0;
    t_out_item             o_item;

    // shadow of the block's registers and state
    logic [THR_W-1:0]   cur_threshold = SETTLE_THRESHOLD_RST;
    logic [SHIFT_W-1:0] cur_shift     = TOLERANCE_SHIFT_RST;
    logic [HZ_W-1:0]    last_rate     = '0;
    logic [MAP_W-1:0]   last_map      = '0;
    logic [THR_W-1:0]   settle_cnt    = '0;
    logic [HZ_W-1:0]    held_rate     = '0;
    logic [MAP_W-1:0]   held_map      = '0;

    t_out_item expected_beats [$];
    t_row      stim_rows [$];
    bit        calm         = 1'b0;
    int        error_count  = 0;
    int        ticks_sent   = 0;
    int        events_seen  = 0;
    int        settings_run = 0;

    audio_rate_change_detector dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_valid    (i_valid),
        .o_stall    (o_stall),
        .i_item     (i_item),
        .o_valid    (o_valid),
        .i_stall    (i_stall),
        .o_item     (o_item)
    );

    always #2 i_clk = ~i_clk;

    // last entry in table order that lies inside its window wins
    function automatic logic [HZ_W-1:0] rate_of_count(input logic [COUNT_W-1:0] cnt);
        logic [HZ_W-1:0]    hz;
        logic [COUNT_W-1:0] nom;
        logic [COUNT_W-1:0] diff;
        hz = '0;
        for (int k = 0; k < RATE_NUM; k++) begin
            nom  = COUNT_W'(NOMINAL_COUNT[k]);
            diff = (cnt >= nom) ? cnt - nom : nom - cnt;
            if (diff < (nom >> cur_shift))
                hz = NOMINAL_HZ[k];
        end
        return hz;
    endfunction

    function automatic t_out_item predict_tick(input t_in_item beat);
        t_out_item       res;
        logic [HZ_W-1:0] hz;
        hz = rate_of_count(beat.rate_count);
        if (hz != last_rate || beat.channel_map != last_map)
            settle_cnt = THR_W'(1);
        last_rate = hz;
        last_map  = beat.channel_map;
        res.event_fire = 1'b0;
        if (settle_cnt >= cur_threshold) begin
            settle_cnt     = '0;
            held_rate      = hz;
            held_map       = beat.channel_map;
            res.event_fire = 1'b1;
        end else if (settle_cnt != 0) begin
            settle_cnt = settle_cnt + 1'b1;
        end
        res.current_rate_hz      = hz;
        res.reported_rate_hz     = held_rate;
        res.reported_channel_map = held_map;
        return res;
    endfunction

    // count near nominal entry k: inside the window, on its edges, or anywhere
    function automatic logic [COUNT_W-1:0] pick_count(input int k, input bit wide);
        int nom;
        int win;
        int off;
        nom = int'(NOMINAL_COUNT[k]);
        win = nom >> cur_shift;
        if (!wide)
            off = (win > 0) ? int'($urandom_range(2 * win - 2)) - (win - 1) : 0;
        else if ($urandom_range(1))
            off = ($urandom_range(1) ? win : -win) + int'($urandom_range(2)) - 1;
        else
            return COUNT_W'($urandom);
        return COUNT_W'(nom + off);
    endfunction

    function automatic t_row tick_row(input int cnt, input int map);
        t_row r;
        r.kind     = ROW_TICK;
        r.reg_idx  = '0;
        r.reg_data = '0;
        r.beat.rate_count  = COUNT_W'(cnt);
        r.beat.channel_map = MAP_W'(map);
        r.typed    = 1'b0;
        r.want     = '0;
        return r;
    endfunction

    function automatic t_row checked_row(input int cnt, input int map, input int cur_hz,
                                         input bit fire, input int rep_hz, input int rep_map);
        t_row r;
        r = tick_row(cnt, map);
        r.typed = 1'b1;
        r.want.current_rate_hz      = HZ_W'(cur_hz);
        r.want.event_fire           = fire;
        r.want.reported_rate_hz     = HZ_W'(rep_hz);
        r.want.reported_channel_map = MAP_W'(rep_map);
        return r;
    endfunction

    function automatic t_row reg_row(input logic [CFG_IDX_W-1:0] idx, input int data);
        t_row r;
        r = tick_row(0, 0);
        r.kind     = ROW_REG;
        r.reg_idx  = idx;
        r.reg_data = CFG_DATA_W'(data);
        return r;
    endfunction

    task automatic send_tick(input t_in_item beat, input bit typed, input t_out_item want);
        t_out_item pred;
        while (!calm && $urandom_range(99) < 21) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_item  <= beat;
        @(posedge i_clk);
        while (o_stall)
            @(posedge i_clk);
        pred = predict_tick(beat);
        expected_beats.push_back(typed ? want : pred);
        ticks_sent++;
    endtask

    // only once the pipeline has drained
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (expected_beats.size() != 0)
            @(posedge i_clk);
        repeat (4) @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        if (idx == CFG_SETTLE_THRESHOLD)
            cur_threshold = data;
        else
            cur_shift = data[SHIFT_W-1:0];
    endtask

    always @(posedge i_clk) begin : result_check
        t_out_item want;
        if (i_rst_n && o_valid && !i_stall) begin
            if (o_item.event_fire)
                events_seen++;
            if (expected_beats.size() == 0) begin
                error_count++;
                $display("%0t: unexpected result beat: rate %0d fire %0d rep %0d map %h",
                         $realtime, o_item.current_rate_hz, o_item.event_fire,
                         o_item.reported_rate_hz, o_item.reported_channel_map);
            end else begin
                want = expected_beats.pop_front();
                if (o_item !== want) begin
                    error_count++;
                    $display("%0t: mismatch exp %0d %0d %0d %h, got %0d %0d %0d %h",
                             $realtime, want.current_rate_hz, want.event_fire,
                             want.reported_rate_hz, want.reported_channel_map,
                             o_item.current_rate_hz, o_item.event_fire,
                             o_item.reported_rate_hz, o_item.reported_channel_map);
                end
            end
        end
        i_stall <= i_rst_n && !calm && ($urandom_range(99) < 21);
    end

    initial begin
        int        thr_set  [8];
        int        shift_set[8];
        int        budget   [8];
        t_in_item  beat;
        t_out_item none;
        int        k;
        int        run;
        int        n;
        bit        clean;
        logic [MAP_W-1:0] map;

        none = '0;
        thr_set   = '{30, 1, 255, 0, 4, 12, 2, 0};
        shift_set = '{7, 0, 7, 3, 15, 5, 9, 0};
        budget    = '{200, 200, 500, 150, 150, 250, 200, 250};
        thr_set[7]   = $urandom_range(1, 40);
        shift_set[7] = $urandom_range(15);

        // reset values first, then each nominal count, then the edges of the 32 kHz window
        stim_rows.push_back(checked_row(0, 0, 0, 1'b0, 0, 0));
        stim_rows.push_back(checked_row(262143, 255, 0, 1'b0, 0, 0));
        stim_rows.push_back(tick_row(4194, 8'h01));
        stim_rows.push_back(tick_row(5780, 8'h02));
        stim_rows.push_back(tick_row(6291, 8'h04));
        stim_rows.push_back(tick_row(11561, 8'h08));
        stim_rows.push_back(tick_row(12583, 8'h10));
        stim_rows.push_back(tick_row(23121, 8'h20));
        stim_rows.push_back(tick_row(25166, 8'h40));
        stim_rows.push_back(tick_row(4225, 8'h03));
        stim_rows.push_back(tick_row(4226, 8'h03));
        stim_rows.push_back(tick_row(4163, 8'h03));
        stim_rows.push_back(tick_row(4162, 8'h03));
        // threshold of one reports on the tick the change is seen
        stim_rows.push_back(reg_row(CFG_SETTLE_THRESHOLD, 1));
        stim_rows.push_back(checked_row(6291, 8'hA5, 48000, 1'b1, 48000, 8'hA5));
        stim_rows.push_back(checked_row(6291, 8'hA5, 48000, 1'b0, 48000, 8'hA5));
        // zero shift: windows overlap and the last match wins
        stim_rows.push_back(reg_row(CFG_TOLERANCE_SHIFT, 0));
        stim_rows.push_back(tick_row(6000, 8'hA5));
        stim_rows.push_back(tick_row(0, 8'hA5));
        // widest shift leaves an empty window
        stim_rows.push_back(reg_row(CFG_TOLERANCE_SHIFT, 15));
        stim_rows.push_back(tick_row(4194, 8'h80));
        // zero threshold fires on every tick
        stim_rows.push_back(reg_row(CFG_SETTLE_THRESHOLD, 0));
        stim_rows.push_back(checked_row(100, 0, 0, 1'b1, 0, 0));
        stim_rows.push_back(checked_row(100, 0, 0, 1'b1, 0, 0));
        stim_rows.push_back(reg_row(CFG_SETTLE_THRESHOLD, 255));
        stim_rows.push_back(tick_row(5780, 8'h01));

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (stim_rows[r]) begin
            if (stim_rows[r].kind == ROW_REG)
                write_reg(stim_rows[r].reg_idx, stim_rows[r].reg_data);
            else
                send_tick(stim_rows[r].beat, stim_rows[r].typed, stim_rows[r].want);
        end

        for (int p = 0; p < 8; p++) begin
            write_reg(CFG_SETTLE_THRESHOLD, CFG_DATA_W'(thr_set[p]));
            // upper data bits are not part of the shift register
            write_reg(CFG_TOLERANCE_SHIFT, {4'($urandom), SHIFT_W'(shift_set[p])});
            settings_run++;
            calm <= (p == 2);
            n = 0;
            while (n < budget[p]) begin
                k     = $urandom_range(RATE_NUM - 1);
                map   = MAP_W'($urandom);
                clean = 1'($urandom_range(1));
                run   = ($urandom_range(9) == 0) ? $urandom_range(1, 3)
                                                 : $urandom_range(1, cur_threshold + 6);
                for (int j = 0; j < run && n < budget[p]; j++) begin
                    beat.rate_count  = pick_count(k, !clean && $urandom_range(99) < 8);
                    beat.channel_map = (!clean && $urandom_range(19) == 0) ? MAP_W'($urandom)
                                                                           : map;
                    send_tick(beat, 1'b0, none);
                    n++;
                end
            end
        end

        i_valid <= 1'b0;
        calm    <= 1'b0;
        @(posedge i_clk);
        while (expected_beats.size() != 0)
            @(posedge i_clk);
        repeat (10) @(posedge i_clk);

        $display("ran %0d poll ticks over %0d register settings plus the directed table,",
                 ticks_sent, settings_run);
        $display("with %0d settled rate or map changes reported", events_seen);
        if (error_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

    initial begin
        #2_000_000;
        $display("timeout with %0d result beats outstanding", expected_beats.size());
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

// File: filelist.f
design/arcd_pkg.sv
design/arcd_front.sv
design/arcd_queue.sv
design/arcd_back.sv
design/audio_rate_change_detector.sv
tb/sv/audio_rate_change_detector_test.sv
